>>> hw/rtl/lbp_pkg.sv
// Shared types and constants for the 3x3 local binary pattern coder.
package lbp_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 256;
    localparam int DEFAULT_MAX_HEIGHT = 256;

    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RESET = 9'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } lbp_in_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } lbp_out_t;

endpackage

>>> hw/rtl/lbp_3x3_texture_code_core.sv
// Top level of the 3x3 local binary pattern coder: line stores, window and output word.
// Stage 1 takes the line-store reads of the word that completes a window and forms the
// code of its centre pixel; the output register is loaded as stage 1 advances, which
// waits while an untaken output word is held.
// Throughput: one pixel word per cycle unless an untaken output word holds stage 1, set by
// each line store's read-modify-write: read per accepted word, write as stage 1 advances.
// Reset: counters, window, valid flags and configuration registers return to defaults;
// the line stores and data registers are not cleared and need no clearing pass.
module lbp_3x3_texture_code_core
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lbp_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lbp_out_t               m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int SZ_W = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                          $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
    localparam int SZ_H = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                          $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;
    localparam logic [SZ_W-1:0] W_MAX = SZ_W'(MAX_WIDTH);
    localparam logic [SZ_H-1:0] H_MAX = SZ_H'(MAX_HEIGHT);
    localparam logic [SZ_W-1:0] W_MIN = SZ_W'(3);
    localparam logic [SZ_H-1:0] H_MIN = SZ_H'(3);

    // Configuration
    logic [CFG_DATA_W-1:0] width_cfg_reg;
    logic [CFG_DATA_W-1:0] height_cfg_reg;
    logic [SZ_W-1:0]       width_ext;
    logic [SZ_H-1:0]       height_ext;
    logic [SZ_W-1:0]       width_use;
    logic [SZ_H-1:0]       height_use;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= IMAGE_WIDTH_RESET;
            height_cfg_reg <= IMAGE_HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign width_ext  = SZ_W'(width_cfg_reg);
    assign height_ext = SZ_H'(height_cfg_reg);

    always_comb begin
        if (width_ext < W_MIN)       width_use = W_MIN;
        else if (width_ext > W_MAX)  width_use = W_MAX;
        else                         width_use = width_ext;
        if (height_ext < H_MIN)      height_use = H_MIN;
        else if (height_ext > H_MAX) height_use = H_MAX;
        else                         height_use = height_ext;
    end

    // Position counters, advanced as each word is accepted
    logic [CW-1:0] col_reg, col_next, col_eff;
    logic [RW-1:0] row_reg, row_next, row_eff;
    logic [SZ_W-1:0] col_plus;
    logic [SZ_H-1:0] row_plus;
    logic          s_accept;
    logic          in_has, in_last;

    assign s_accept = s_valid && s_ready;
    assign col_eff  = s_data.frame_start ? '0 : col_reg;
    assign row_eff  = s_data.frame_start ? '0 : row_reg;
    assign col_plus = SZ_W'(col_eff) + SZ_W'(1);
    assign row_plus = SZ_H'(row_eff) + SZ_H'(1);
    assign in_has   = (row_eff >= RW'(2)) && (col_eff >= CW'(2));
    assign in_last  = (row_plus == height_use) && (col_plus == width_use);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (col_plus >= width_use) begin
                col_next = '0;
                row_next = (row_plus >= height_use) ? '0 : row_eff + RW'(1);
            end else begin
                col_next = col_eff + CW'(1);
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: line-store data arrives, code is formed, stores are written back
    logic          s1_valid_reg;
    logic [7:0]    s1_px_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_has_reg;
    logic          s1_last_reg;
    logic          s1_fwd_reg;
    logic [7:0]    s1_fwd_a_reg;
    logic [7:0]    s1_fwd_b_reg;
    logic          s1_advance;
    logic          out_load;
    logic          m_valid_reg;
    lbp_out_t      m_data_reg;

    logic [7:0] line_a_mem [MAX_WIDTH];
    logic [7:0] line_b_mem [MAX_WIDTH];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;
    logic [7:0] top, mid;
    logic [7:0] win_reg [6];
    logic [7:0] ctr;
    logic [7:0] code;

    assign s1_advance = s1_valid_reg && (!s1_has_reg || !m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign out_load   = s1_advance && s1_has_reg;

    // A word on the same column as the one being written back reads stale data,
    // so the values being written are carried along with it instead.
    assign mid = s1_fwd_reg ? s1_fwd_a_reg : rd_a_reg;
    assign top = s1_fwd_reg ? s1_fwd_b_reg : rd_b_reg;

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            line_a_mem[s1_col_reg] <= s1_px_reg;
            line_b_mem[s1_col_reg] <= mid;
        end
        if (s_accept) begin
            rd_a_reg <= line_a_mem[col_eff];
            rd_b_reg <= line_b_mem[col_eff];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_px_reg    <= s_data.pixel;
            s1_col_reg   <= col_eff;
            s1_has_reg   <= in_has;
            s1_last_reg  <= in_last;
            s1_fwd_reg   <= s1_advance && (s1_col_reg == col_eff);
            s1_fwd_a_reg <= s1_px_reg;
            s1_fwd_b_reg <= mid;
        end
    end

    // Window: entries 0..2 are column c-2 (top, middle, bottom), 3..5 column c-1.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end else if (s1_advance) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= s1_px_reg;
        end
    end

    assign ctr = win_reg[4];

    always_comb begin
        code[0] = win_reg[0] > ctr;
        code[1] = win_reg[1] > ctr;
        code[2] = win_reg[2] > ctr;
        code[3] = win_reg[5] > ctr;
        code[4] = s1_px_reg  > ctr;
        code[5] = mid        > ctr;
        code[6] = top        > ctr;
        code[7] = win_reg[3] > ctr;
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.code <= code;
            m_data_reg.last <= s1_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_frame_start_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_data.frame_start |=> s1_col_reg == '0 && s1_has_reg == 1'b0)
        else $error("frame start did not restart at the first column");

    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_col_reg)
            && $stable(s1_px_reg))
        else $error("stalled stage 1 word changed");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !out_load)
        else $error("output word overwritten before it was taken");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg && m_data_reg.code == $past(code))
        else $error("code not presented after stage 1 advance");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the 3x3 local binary pattern coder, with its own predictor.
module tb_top
    import lbp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int STALL_CYCLES = 200;
    localparam int PHASE_WORDS = 80;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_QUIET,
        ROW_TYPED,
        ROW_PREDICT
    } row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        cfg_index_t      reg_idx;
        logic [8:0]      reg_val;
        logic [7:0]      pixel;
        logic            frame_start;
        logic [7:0]      want_code;
        logic            want_last;
    } stim_row_t;

    // Opening sequence: two words at the reset geometry, then 3x3 frames whose codes can be
    // read straight off the pixels, then a frame restarted part way through.
    localparam stim_row_t DIRECTED_ROWS [26] = '{
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd0,   1'b1, 8'd0,   1'b0},
        '{ROW_WRITE,   CFG_IMAGE_WIDTH,  9'd0, 8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_WRITE,   CFG_IMAGE_HEIGHT, 9'd2, 8'd0,   1'b0, 8'd0,   1'b0},
        // Dark centre among bright neighbours sets every bit.
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b1, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_TYPED,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b0, 8'hFF,  1'b1},
        // Next frame follows on from the wrap alone; ties with the centre leave bits clear.
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd129, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd200, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd128, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd128, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd127, 1'b0, 8'd0,   1'b0},
        '{ROW_QUIET,   CFG_IMAGE_WIDTH,  9'd0, 8'd129, 1'b0, 8'd0,   1'b0},
        '{ROW_TYPED,   CFG_IMAGE_WIDTH,  9'd0, 8'd0,   1'b0, 8'd105, 1'b1},
        '{ROW_PREDICT, CFG_IMAGE_WIDTH,  9'd0, 8'd3,   1'b0, 8'd0,   1'b0},
        '{ROW_PREDICT, CFG_IMAGE_WIDTH,  9'd0, 8'd250, 1'b0, 8'd0,   1'b0},
        '{ROW_PREDICT, CFG_IMAGE_WIDTH,  9'd0, 8'd77,  1'b1, 8'd0,   1'b0},
        '{ROW_PREDICT, CFG_IMAGE_WIDTH,  9'd0, 8'd0,   1'b0, 8'd0,   1'b0}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    lbp_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    lbp_out_t               m_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Predictor state: geometry as written, the two previous rows, the window and counters.
    logic [8:0] geom_w = IMAGE_WIDTH_RESET;
    logic [8:0] geom_h = IMAGE_HEIGHT_RESET;
    logic [7:0] prev_row  [DEFAULT_MAX_WIDTH] = '{default: '0};
    logic [7:0] prev2_row [DEFAULT_MAX_WIDTH] = '{default: '0};
    logic [7:0] win [6] = '{default: '0};
    int         row_cnt = 0;
    int         col_cnt = 0;

    lbp_out_t   expected_codes [$];
    int         bad_words = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         stall_armed = 1'b0;
    bit         stall_done = 1'b0;

    lbp_3x3_texture_code_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5ns aclk = ~aclk;

    function automatic int clamp_dim(input logic [8:0] raw, input int hi);
        if (raw < 3) return 3;
        if (raw > hi) return hi;
        return int'(raw);
    endfunction

    function automatic void predict_lbp(input lbp_in_t word, output bit has,
                                        output lbp_out_t res);
        int         cw;
        int         ch;
        int         col;
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] ctr;
        logic [7:0] code;
        cw = clamp_dim(geom_w, DEFAULT_MAX_WIDTH);
        ch = clamp_dim(geom_h, DEFAULT_MAX_HEIGHT);
        if (word.frame_start) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        col = (col_cnt >= DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH - 1 : col_cnt;
        top = prev2_row[col];
        mid = prev_row[col];
        prev2_row[col] = mid;
        prev_row[col] = word.pixel;
        has = 1'b0;
        res = '0;
        if (row_cnt >= 2 && col_cnt >= 2) begin
            // The window holds column c-2 in entries 0..2 and column c-1 in 3..5.
            ctr = win[4];
            code[0] = win[0] > ctr;
            code[1] = win[1] > ctr;
            code[2] = win[2] > ctr;
            code[3] = win[5] > ctr;
            code[4] = word.pixel > ctr;
            code[5] = mid > ctr;
            code[6] = top > ctr;
            code[7] = win[3] > ctr;
            res.code = code;
            res.last = (row_cnt == ch - 1) && (col_cnt == cw - 1);
            has = 1'b1;
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = word.pixel;
        if (col_cnt + 1 >= cw) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= ch) ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
    endfunction

    task automatic send_word(input lbp_in_t word, output bit has, output lbp_out_t res);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= word;
        do @(posedge aclk); while (!s_ready);
        predict_lbp(word, has, res);
    endtask

    // Holds the input quiet until every expected code has come out, then lets the
    // pipeline run dry.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_geometry(input cfg_index_t idx, input logic [8:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_IMAGE_WIDTH) geom_w = val;
        else geom_h = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_armed && !stall_done) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
                stall_done = 1'b1;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        lbp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_codes.size() == 0) begin
                $display("%0t: expected no word, got code %02h last %0b",
                         $time, m_data.code, m_data.last);
                bad_words++;
            end else begin
                want = expected_codes.pop_front();
                if (m_data.code !== want.code) begin
                    $display("%0t: code expected %02h got %02h", $time, want.code, m_data.code);
                    bad_words++;
                end
                if (m_data.last !== want.last) begin
                    $display("%0t: last expected %0b got %0b", $time, want.last, m_data.last);
                    bad_words++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        stim_row_t  row;
        lbp_in_t    word;
        bit         has;
        lbp_out_t   res;
        int         phase_words;
        int         frame_len;
        int         cw;
        int         ch;
        int         mode;
        logic [7:0] base;
        logic [8:0] raw_w;
        logic [8:0] raw_h;
        bit         forced;
        bit         fresh;
        bit         start_flag;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_WRITE) begin
                settle();
                write_geometry(row.reg_idx, row.reg_val);
            end else begin
                word.pixel = row.pixel;
                word.frame_start = row.frame_start;
                send_word(word, has, res);
                if (row.kind == ROW_TYPED) expected_codes.push_back({row.want_code, row.want_last});
                else if (row.kind == ROW_PREDICT && has) expected_codes.push_back(res);
            end
        end

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 6 : (p == 1) ? 57 : 0;
            recv_idle_pct = (p == 0) ? 57 : (p == 1) ? 6 : 0;
            phase_words = 0;
            forced = 1'b1;
            while (phase_words < PHASE_WORDS) begin
                if (forced || $urandom_range(3) == 0) begin
                    settle();
                    if (forced) begin
                        // Each phase opens on an extreme: widest rows, tallest frame,
                        // then a narrow tall frame that keeps codes coming during the stall.
                        case (p)
                            0: begin raw_w = 9'd511; raw_h = 9'd0;   end
                            1: begin raw_w = 9'd2;   raw_h = 9'd256; end
                            default: begin raw_w = 9'd3; raw_h = 9'd40; end
                        endcase
                    end else begin
                        raw_w = 9'($urandom_range(3, 12));
                        raw_h = 9'($urandom_range(3, 8));
                        if ($urandom_range(7) == 0) raw_w = 9'($urandom_range(511));
                        if ($urandom_range(7) == 0) raw_h = 9'($urandom_range(511));
                    end
                    write_geometry(CFG_IMAGE_WIDTH, raw_w);
                    write_geometry(CFG_IMAGE_HEIGHT, raw_h);
                    fresh = 1'b1;
                end
                cw = clamp_dim(raw_w, DEFAULT_MAX_WIDTH);
                ch = clamp_dim(raw_h, DEFAULT_MAX_HEIGHT);
                frame_len = cw * ch;
                if (forced && p == 0) begin
                    // Two full wide rows and the start of the third reach the interior.
                    frame_len = 2 * cw + 6;
                end else if (forced && p == 1) begin
                    frame_len = 100;
                end else if (!forced && (frame_len > 800 || $urandom_range(9) == 0)) begin
                    frame_len = $urandom_range(1, (frame_len > 200) ? 200 : frame_len - 1);
                end
                // A new geometry always begins on a marked frame; otherwise the frame may
                // follow on from wherever the counters stand.
                start_flag = fresh || ($urandom_range(3) != 0);
                mode = $urandom_range(2);
                base = 8'($urandom_range(255));
                if (forced && p == 2) stall_armed = 1'b1;
                for (int i = 0; i < frame_len; i++) begin
                    case (mode)
                        0: word.pixel = 8'($urandom_range(255));
                        1: word.pixel = base ^ 8'($urandom_range(3));
                        default: begin
                            case ($urandom_range(2))
                                0: word.pixel = 8'h00;
                                1: word.pixel = 8'hFF;
                                default: word.pixel = 8'($urandom_range(255));
                            endcase
                        end
                    endcase
                    word.frame_start = (i == 0) ? start_flag : ($urandom_range(255) == 0);
                    send_word(word, has, res);
                    if (has) expected_codes.push_back(res);
                end
                // The two large opening frames are left out of the phase's word count.
                if (!(forced && p < 2)) phase_words += frame_len;
                forced = 1'b0;
                fresh = 1'b0;
            end
        end

        settle();
        if (bad_words == 0 && expected_codes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
